// File: rtl/bdqs_pkg.sv
// Shared types and codes for the bounded deque with search.
package bdqs_pkg;

  // Request codes
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_QUERY      = 3'd3,
    OP_CLEAR      = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic accept;      // an item is taken this cycle
    logic shift_back;  // accepted push at the front: every word moves one cell back
    logic shift_front; // accepted pop at the front: every word moves one cell forward
    logic search;      // membership query: each held cell compares its word
  } cell_ctrl_t;

endpackage

// File: rtl/bdqs_cell.sv
// One cell of the deque chain: holds one word and compares it on a query.
module bdqs_cell import bdqs_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic                  load_i,   // push at the back lands in this cell
  input  logic                  held_i,   // this cell holds a word of the sequence
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] front_nb_i, // word of the neighbor toward the front
  input  logic [DATA_WIDTH-1:0] back_nb_i,  // word of the neighbor toward the back
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  hit_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  hit_q, hit_d;

  // Word movement along the chain
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_back) begin
      data_d = front_nb_i;
    end else if (ctrl_i.shift_front) begin
      data_d = back_nb_i;
    end else if (load_i) begin
      data_d = value_i;
    end
  end

  // Compare result for the item just taken
  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.accept) begin
      hit_d = ctrl_i.search && held_i && (data_q == value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

// File: rtl/bounded_deque_with_search_unit.sv
// Top level of the bounded deque with search: control, cell chain and result stages.
// Each accepted item passes through the compare stage and then the result stage.
// Throughput: one item per cycle while the result stage is not stalled; the cell chain updates
// when an item is accepted and the OR over the per-cell compare flags is taken in the compare stage.
// Reset: the deque is empty and both stages are empty; cell words are undefined until written.
module bounded_deque_with_search_unit import bdqs_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            op_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0] popped_value_o,
  output logic                  found_o,
  output logic [1:0]            status_o,
  output logic [CW-1:0]         count_o,
  output logic [DATA_WIDTH-1:0] front_value_o,
  output logic [DATA_WIDTH-1:0] back_value_o
);

  // Chain wiring
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_hit;
  logic [DEPTH-1:0]      cell_load;
  logic [DEPTH-1:0]      cell_held;
  cell_ctrl_t            ctrl;

  // Deque state
  logic [CW-1:0]         count_q, count_d;
  logic [DATA_WIDTH-1:0] back_q, back_d;

  // Compare stage
  logic                  s1_valid_q, s1_valid_d;
  logic [DATA_WIDTH-1:0] s1_popped_q, s1_popped_d;
  logic [1:0]            s1_status_q, s1_status_d;
  logic [CW-1:0]         s1_count_q;
  logic [DATA_WIDTH-1:0] s1_front_q, s1_front_d;
  logic [DATA_WIDTH-1:0] s1_back_q, s1_back_d;

  // Result stage
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_popped_q;
  logic                  out_found_q;
  logic [1:0]            out_status_q;
  logic [CW-1:0]         out_count_q;
  logic [DATA_WIDTH-1:0] out_front_q;
  logic [DATA_WIDTH-1:0] out_back_q;

  logic in_accept, out_adv, is_empty, is_full, append_ok;

  // Handshake
  assign out_adv    = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_accept || (s1_valid_q && !out_adv);
  assign out_valid_d = out_adv || (out_valid_q && out_stall_i);

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CW'(DEPTH));

  // Request decode and next state
  always_comb begin
    ctrl         = '0;
    ctrl.accept  = in_accept;
    append_ok    = 1'b0;
    count_d      = count_q;
    back_d       = back_q;
    s1_popped_d  = '0;
    s1_status_d  = ST_OK;
    s1_front_d   = is_empty ? '0 : cell_data[0];
    case (op_i)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          s1_status_d = ST_FULL;
        end else begin
          ctrl.shift_back = in_accept;
          count_d         = count_q + CW'(1);
          s1_front_d      = value_i;
          if (is_empty) begin
            back_d = value_i;
          end
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          s1_status_d = ST_FULL;
        end else begin
          append_ok = in_accept;
          count_d   = count_q + CW'(1);
          back_d    = value_i;
          if (is_empty) begin
            s1_front_d = value_i;
          end
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          s1_status_d = ST_EMPTY;
        end else begin
          ctrl.shift_front = in_accept;
          count_d          = count_q - CW'(1);
          s1_popped_d      = cell_data[0];
          s1_front_d       = (count_q == CW'(1)) ? '0 : cell_data[1];
        end
      end
      OP_QUERY: begin
        ctrl.search = 1'b1;
      end
      OP_CLEAR: begin
        count_d    = '0;
        s1_front_d = '0;
      end
      default: begin
      end
    endcase
    s1_back_d = (count_d == '0) ? '0 : back_d;
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_held[i] = (CW'(i) < count_q);
    assign cell_load[i] = append_ok && (count_q == CW'(i));

    if (i == 0) begin : g_first
      if (DEPTH > 1) begin : g_more
        bdqs_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
          .clk_i, .rst_ni, .ctrl_i(ctrl), .load_i(cell_load[i]), .held_i(cell_held[i]),
          .value_i, .front_nb_i(value_i), .back_nb_i(cell_data[i+1]),
          .data_o(cell_data[i]), .hit_o(cell_hit[i])
        );
      end else begin : g_single
        bdqs_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
          .clk_i, .rst_ni, .ctrl_i(ctrl), .load_i(cell_load[i]), .held_i(cell_held[i]),
          .value_i, .front_nb_i(value_i), .back_nb_i(cell_data[i]),
          .data_o(cell_data[i]), .hit_o(cell_hit[i])
        );
      end
    end else if (i == DEPTH - 1) begin : g_last
      bdqs_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
        .clk_i, .rst_ni, .ctrl_i(ctrl), .load_i(cell_load[i]), .held_i(cell_held[i]),
        .value_i, .front_nb_i(cell_data[i-1]), .back_nb_i(cell_data[i]),
        .data_o(cell_data[i]), .hit_o(cell_hit[i])
      );
    end else begin : g_mid
      bdqs_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
        .clk_i, .rst_ni, .ctrl_i(ctrl), .load_i(cell_load[i]), .held_i(cell_held[i]),
        .value_i, .front_nb_i(cell_data[i-1]), .back_nb_i(cell_data[i+1]),
        .data_o(cell_data[i]), .hit_o(cell_hit[i])
      );
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        count_q <= count_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      back_q      <= back_d;
      s1_popped_q <= s1_popped_d;
      s1_status_q <= s1_status_d;
      s1_count_q  <= count_d;
      s1_front_q  <= s1_front_d;
      s1_back_q   <= s1_back_d;
    end
    if (out_adv) begin
      out_popped_q <= s1_popped_q;
      out_found_q  <= |cell_hit;
      out_status_q <= s1_status_q;
      out_count_q  <= s1_count_q;
      out_front_q  <= s1_front_q;
      out_back_q   <= s1_back_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_popped_q;
  assign found_o        = out_found_q;
  assign status_o       = out_status_q;
  assign count_o        = out_count_q;
  assign front_value_o  = out_front_q;
  assign back_value_o   = out_back_q;

endmodule

// File: test/tb.sv
// Self-checking testbench for the bounded deque with search unit.
module tb;
  import bdqs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 1800;

  // Op codes the block must treat as no-ops
  localparam logic [2:0] OP_UNUSED_5 = 3'd5;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  // Request mix used by the random part
  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_e;

  typedef struct {
    logic [31:0] popped;
    logic        found;
    status_e     status;
    logic [4:0]  count;
    logic [31:0] front;
    logic [31:0] back;
  } deque_result_t;

  // One directed row: repeated reps times with the word counting up
  typedef struct {
    logic [2:0]  op;
    logic [31:0] word;
    int          reps;
    bit          typed;
    logic [31:0] popped;
    bit          found;
    status_e     status;
    int          count;
    logic [31:0] front;
    logic [31:0] back;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  op_i = OP_CLEAR;
  logic [31:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] popped_value_o;
  logic        found_o;
  logic [1:0]  status_o;
  logic [4:0]  count_o;
  logic [31:0] front_value_o;
  logic [31:0] back_value_o;

  bit idle_on = 1'b1;

  // Shadow deque contents and the results still owed by the block
  logic [31:0]   held_words[$];
  deque_result_t awaited_results[$];

  int n_errors = 0;
  int n_compared = 0;
  int n_hits = 0;
  int n_refused = 0;
  int n_empty_pops = 0;
  int n_clears = 0;
  int n_full_seen = 0;

  stim_row_t directed_rows[] = '{
    '{OP_POP_FRONT,  32'h0000_0000, 1,  1, 32'h0000_0000, 0, ST_EMPTY, 0,  32'h0, 32'h0},
    '{OP_QUERY,      32'h0000_0000, 1,  1, 32'h0000_0000, 0, ST_OK,    0,  32'h0, 32'h0},
    '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1,  1, 32'h0000_0000, 0, ST_OK,    1,
      32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{OP_PUSH_FRONT, 32'h8000_0000, 1,  1, 32'h0000_0000, 0, ST_OK,    2,
      32'h8000_0000, 32'h7FFF_FFFF},
    '{OP_QUERY,      32'h8000_0000, 1,  1, 32'h0000_0000, 1, ST_OK,    2,
      32'h8000_0000, 32'h7FFF_FFFF},
    '{OP_QUERY,      32'hFFFF_FFFF, 1,  1, 32'h0000_0000, 0, ST_OK,    2,
      32'h8000_0000, 32'h7FFF_FFFF},
    '{OP_POP_FRONT,  32'h0000_0000, 1,  1, 32'h8000_0000, 0, ST_OK,    1,
      32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{OP_POP_FRONT,  32'h0000_0000, 1,  1, 32'h7FFF_FFFF, 0, ST_OK,    0,  32'h0, 32'h0},
    '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1,  0, 32'h0, 0, ST_OK, 0, 32'h0, 32'h0},
    '{OP_UNUSED_5,   32'hFFFF_FFFF, 1,  1, 32'h0000_0000, 0, ST_OK,    1,
      32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{OP_CLEAR,      32'h0000_0000, 1,  1, 32'h0000_0000, 0, ST_OK,    0,  32'h0, 32'h0},
    '{OP_UNUSED_7,   32'h0000_0000, 1,  1, 32'h0000_0000, 0, ST_OK,    0,  32'h0, 32'h0},
    '{OP_PUSH_BACK,  32'h0000_1000, 16, 0, 32'h0, 0, ST_OK, 0, 32'h0, 32'h0},
    '{OP_PUSH_FRONT, 32'h0000_DEAD, 1,  1, 32'h0000_0000, 0, ST_FULL,  16,
      32'h0000_1000, 32'h0000_100F},
    '{OP_PUSH_BACK,  32'h0000_BEEF, 1,  1, 32'h0000_0000, 0, ST_FULL,  16,
      32'h0000_1000, 32'h0000_100F},
    '{OP_QUERY,      32'h0000_100F, 1,  0, 32'h0, 0, ST_OK, 0, 32'h0, 32'h0},
    '{OP_QUERY,      32'h0000_1010, 1,  0, 32'h0, 0, ST_OK, 0, 32'h0, 32'h0},
    '{OP_UNUSED_6,   32'h0000_1000, 1,  0, 32'h0, 0, ST_OK, 0, 32'h0, 32'h0},
    '{OP_CLEAR,      32'h0000_0000, 1,  1, 32'h0000_0000, 0, ST_OK,    0,  32'h0, 32'h0},
    '{OP_PUSH_FRONT, 32'h0000_2000, 16, 0, 32'h0, 0, ST_OK, 0, 32'h0, 32'h0},
    '{OP_POP_FRONT,  32'h0000_0000, 17, 0, 32'h0, 0, ST_OK, 0, 32'h0, 32'h0},
    '{OP_PUSH_BACK,  32'h5555_5555, 1,  0, 32'h0, 0, ST_OK, 0, 32'h0, 32'h0},
    '{OP_PUSH_FRONT, 32'hAAAA_AAAA, 1,  0, 32'h0, 0, ST_OK, 0, 32'h0, 32'h0},
    '{OP_QUERY,      32'h5555_5555, 1,  0, 32'h0, 0, ST_OK, 0, 32'h0, 32'h0},
    '{OP_CLEAR,      32'h0000_0000, 1,  0, 32'h0, 0, ST_OK, 0, 32'h0, 32'h0}
  };

  bounded_deque_with_search_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .popped_value_o (popped_value_o),
    .found_o        (found_o),
    .status_o       (status_o),
    .count_o        (count_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one request to the shadow deque and return the result it owes
  task automatic step_deque(input logic [2:0] op, input logic [31:0] word,
                            output deque_result_t r);
    r = '{popped: '0, found: 1'b0, status: ST_OK, count: '0, front: '0, back: '0};
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (held_words.size() >= DEPTH) begin
          r.status = ST_FULL;
          n_refused++;
        end else if (op == OP_PUSH_FRONT) begin
          held_words.insert(0, word);
        end else begin
          held_words.insert(held_words.size(), word);
        end
      end
      OP_POP_FRONT: begin
        if (held_words.size() == 0) begin
          r.status = ST_EMPTY;
          n_empty_pops++;
        end else begin
          r.popped = held_words[0];
          held_words.delete(0);
        end
      end
      OP_QUERY: begin
        foreach (held_words[k]) if (held_words[k] == word) r.found = 1'b1;
        if (r.found) n_hits++;
      end
      OP_CLEAR: begin
        held_words.delete();
        n_clears++;
      end
      default: ;
    endcase
    r.count = 5'(held_words.size());
    if (held_words.size() == DEPTH) n_full_seen++;
    if (held_words.size() != 0) begin
      r.front = held_words[0];
      r.back  = held_words[$];
    end
  endtask

  // Present one item, wait for acceptance, then record what it owes
  task automatic send_item(input logic [2:0] op, input logic [31:0] word,
                           input bit typed, input deque_result_t typed_r);
    deque_result_t r;
    while (idle_on && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    step_deque(op, word, r);
    awaited_results.insert(awaited_results.size(), typed ? typed_r : r);
  endtask

  // Hold off new items until every owed result is back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [2:0] pick_op(mix_e mix);
    int roll;
    int push_lim;
    int pop_lim;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  begin push_lim = 62; pop_lim = 78; end
      MIX_DRAIN: begin push_lim = 20; pop_lim = 70; end
      default:   begin push_lim = 35; pop_lim = 65; end
    endcase
    if (roll < push_lim) return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (roll < pop_lim) return OP_POP_FRONT;
    if (roll < 94) return OP_QUERY;
    if (roll < 97) return OP_CLEAR;
    return 3'($urandom_range(OP_UNUSED_7, OP_UNUSED_5));
  endfunction

  // Mostly full-range words; some extremes and a small set to force repeats
  function automatic logic [31:0] pick_word(logic [2:0] op);
    int roll;
    roll = $urandom_range(99);
    if (op == OP_QUERY && held_words.size() != 0 && roll < 50)
      return held_words[$urandom_range(held_words.size() - 1)];
    roll = $urandom_range(99);
    if (roll < 10) begin
      case ($urandom_range(3))
        0:       return 32'h0000_0000;
        1:       return 32'h8000_0000;
        2:       return 32'h7FFF_FFFF;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (roll < 30) return 32'($urandom_range(7));
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    $display("%0t ERROR %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 15);
  end

  // Compare each accepted result with the oldest owed one
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with none owed", 32'd1, 32'd0);
      end else begin
        want = awaited_results[0];
        awaited_results.delete(0);
        n_compared++;
        if (popped_value_o !== want.popped)
          report_mismatch("popped_value", popped_value_o, want.popped);
        if (found_o !== want.found) report_mismatch("found", 32'(found_o), 32'(want.found));
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (count_o !== want.count) report_mismatch("count", 32'(count_o), 32'(want.count));
        if (front_value_o !== want.front)
          report_mismatch("front_value", front_value_o, want.front);
        if (back_value_o !== want.back)
          report_mismatch("back_value", back_value_o, want.back);
      end
    end
  end

  // Main stimulus
  initial begin
    deque_result_t typed_r;
    deque_result_t none_r;
    mix_e          mix;
    logic [2:0]    op;
    int            waited;

    none_r = '{popped: '0, found: 1'b0, status: ST_OK, count: '0, front: '0, back: '0};
    mix = MIX_FILL;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    foreach (directed_rows[i]) begin
      typed_r = '{popped: directed_rows[i].popped, found: directed_rows[i].found,
                  status: directed_rows[i].status, count: 5'(directed_rows[i].count),
                  front: directed_rows[i].front, back: directed_rows[i].back};
      for (int k = 0; k < directed_rows[i].reps; k++)
        send_item(directed_rows[i].op, directed_rows[i].word + 32'(k),
                  directed_rows[i].typed, typed_r);
    end
    wait_for_drain();

    // Random part: the mix is drawn anew every 40 items so the deque swings full and empty
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) mix = mix_e'($urandom_range(2));
      idle_on = !(n >= 700 && n < 1100);
      if (n % 300 == 299) wait_for_drain();
      op = pick_op(mix);
      send_item(op, pick_word(op), 1'b0, none_r);
    end

    // Drain and give a spurious result a chance to show up
    in_valid_i <= 1'b0;
    waited = 0;
    while (awaited_results.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (6) @(posedge clk_i);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", awaited_results.size(), 32'd0);

    $display("Checked %0d results: %0d query hits, %0d refused pushes, %0d empty pops,",
             n_compared, n_hits, n_refused, n_empty_pops);
    $display("%0d clears, %0d requests leaving the deque full.", n_clears, n_full_seen);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
rtl/bdqs_pkg.sv
rtl/bdqs_cell.sv
rtl/bounded_deque_with_search_unit.sv
test/tb.sv
